// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each helper checks on the rising edge of clk
// and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every checked clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the trigger is seen, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

// File: sv/flais_pkg.sv
package flais_pkg;

  localparam int REQ_W    = 8;
  localparam int TARGET_W = 8;
  localparam int TIMEOUT_W = 16;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_ACQUIRE = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] KIND_OK     = 2'd0;
  localparam logic [1:0] KIND_SLEEP  = 2'd1;
  localparam logic [1:0] KIND_WAKE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       func;
    logic [REQ_W-1:0] requester;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [TARGET_W-1:0] target;
    logic                last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SECOND
  } state_t;

endpackage

// File: sv/flais_ram.sv
module flais_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/fifo_lock_arbiter_idle_sleep.sv
// Lock server for one shared resource with a first-come queue of waiting requester ids
// and an idle low-power mode. A command is taken when start is high and busy is low;
// it is then carried out in ST_EXEC, followed by ST_SECOND when it yields two results (a wake
// event before the reply, or a release that hands the lock to the oldest waiter). The command
// and the read of the waiter memory are registered as the command is taken; ST_SECOND
// comes from the single result port.
// Each result is shown on rsp for exactly one cycle with rsp_valid high; the receiver
// cannot hold it off, so it must take every result as it appears. rsp.last marks the
// final result of a command. Ticks and queued acquires may yield no result at all.
// The idle timeout register may only be written while busy is low.
`include "assert_macros.svh"

module fifo_lock_arbiter_idle_sleep
  import flais_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output logic                 rsp_valid,
  output rsp_t                 rsp,
  input  logic                 idle_timeout_we,
  input  logic [TIMEOUT_W-1:0] idle_timeout_data
);

  localparam int StoreW = (ID_BITS < REQ_W) ? ID_BITS : REQ_W;
  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;
  cmd_t   cur;
  logic   owned, owned_next;
  logic   sleeping, sleeping_next;
  logic [TIMEOUT_W-1:0] quiet_ticks, quiet_ticks_next;
  logic [TIMEOUT_W-1:0] idle_timeout;
  logic [PtrW-1:0]      head_ptr, head_ptr_next;
  logic [PtrW-1:0]      tail_ptr, tail_ptr_next;
  logic [CntW-1:0]      waiting_count, waiting_count_next;
  rsp_t                 second, second_next;

  logic                 ram_we;
  logic [StoreW-1:0]    ram_rdata;
  logic [StoreW-1:0]    id;
  logic [TIMEOUT_W-1:0] limit, ticks_inc;
  logic                 full;
  logic                 wake_v, main_v, hand_v;
  rsp_t                 wake_r, main_r, hand_r;
  logic                 first_v, second_v;
  rsp_t                 first_r;

  flais_ram #(
    .WIDTH (StoreW),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_ptr),
    .wdata (id),
    .raddr (head_ptr),
    .rdata (ram_rdata)
  );

  assign id    = cur.requester[StoreW-1:0];
  assign limit = (idle_timeout == '0) ? TIMEOUT_W'(1) : idle_timeout;
  assign full  = (waiting_count == CntW'(QUEUE_DEPTH));

  // Work out the effect of the held command; results are listed in the order they leave.
  always_comb begin
    owned_next         = owned;
    sleeping_next      = sleeping;
    quiet_ticks_next   = quiet_ticks;
    head_ptr_next      = head_ptr;
    tail_ptr_next      = tail_ptr;
    waiting_count_next = waiting_count;
    ram_we             = 1'b0;
    ticks_inc          = (quiet_ticks == TICKS_MAX) ? quiet_ticks : quiet_ticks + 16'd1;
    wake_v             = 1'b0;
    main_v             = 1'b0;
    hand_v             = 1'b0;
    wake_r             = '{kind: KIND_WAKE, target: '0, last: 1'b0};
    main_r             = '{kind: KIND_OK, target: TARGET_W'(id), last: 1'b0};
    hand_r             = '{kind: KIND_OK, target: TARGET_W'(ram_rdata), last: 1'b0};
    if (state == ST_EXEC) begin
      case (cur.func) inside
        FUNC_TICK: begin
          if (!owned && !sleeping) begin
            if (ticks_inc >= limit) begin
              quiet_ticks_next = '0;
              sleeping_next    = 1'b1;
              main_v           = 1'b1;
              main_r.kind      = KIND_SLEEP;
              main_r.target    = '0;
            end else begin
              quiet_ticks_next = ticks_inc;
            end
          end
        end
        FUNC_ACQUIRE, FUNC_RELEASE: begin
          quiet_ticks_next = '0;
          sleeping_next    = 1'b0;
          wake_v           = sleeping;
          if (cur.func == FUNC_ACQUIRE) begin
            if (!owned) begin
              owned_next = 1'b1;
              main_v     = 1'b1;
            end else if (full) begin
              main_v      = 1'b1;
              main_r.kind = KIND_REJECT;
            end else begin
              ram_we             = 1'b1;
              tail_ptr_next      = (tail_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : tail_ptr + PtrW'(1);
              waiting_count_next = waiting_count + CntW'(1);
            end
          end else begin
            main_v = 1'b1;
            if (waiting_count != '0) begin
              hand_v             = 1'b1;
              head_ptr_next      = (head_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : head_ptr + PtrW'(1);
              waiting_count_next = waiting_count - CntW'(1);
            end else begin
              owned_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    // A wake event only happens while the lock is free, so no command has three results.
    first_v     = wake_v || main_v || hand_v;
    first_r     = wake_v ? wake_r : (main_v ? main_r : hand_r);
    second_v    = wake_v ? (main_v || hand_v) : (main_v && hand_v);
    second_next = wake_v ? (main_v ? main_r : hand_r) : hand_r;
    second_next.last = 1'b1;
    first_r.last     = !second_v;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_EXEC;
      ST_EXEC:   state_next = second_v ? ST_SECOND : ST_IDLE;
      ST_SECOND: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    rsp_valid = 1'b0;
    rsp       = second;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        rsp_valid = first_v;
        rsp       = first_r;
      end
      ST_SECOND: rsp_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      owned         <= 1'b0;
      sleeping      <= 1'b0;
      quiet_ticks   <= '0;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      waiting_count <= '0;
      idle_timeout  <= TIMEOUT_RESET;
    end else begin
      state         <= state_next;
      owned         <= owned_next;
      sleeping      <= sleeping_next;
      quiet_ticks   <= quiet_ticks_next;
      head_ptr      <= head_ptr_next;
      tail_ptr      <= tail_ptr_next;
      waiting_count <= waiting_count_next;
      if (idle_timeout_we) begin
        idle_timeout <= idle_timeout_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur <= cmd;
    end
    if (state == ST_EXEC) begin
      second <= second_next;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, waiting_count <= CntW'(QUEUE_DEPTH), "waiter count overflow")
  `ASSERT_IMPLIES(a_sleep_free, sleeping, !owned && waiting_count == '0, "asleep while held")
  `ASSERT_IMPLIES(a_second_last, state == ST_SECOND, rsp_valid && rsp.last,
                  "second result not marked last")
  `ASSERT_IMPLIES(a_second_order, state == ST_SECOND, $past(state) == ST_EXEC,
                  "second result without a first")
  `ASSERT_IMPLIES(a_valid_busy, rsp_valid, busy, "result shown while idle")

endmodule

// File: verif/fifo_lock_arbiter_idle_sleep_tb.sv
module fifo_lock_arbiter_idle_sleep_tb;
  import flais_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WAIT_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int RANDOM_ITEMS  = 1000;

  // A backlog entry is either a command or a barrier. A barrier waits until the
  // block is quiet and nothing is owed, and may then write the timeout register.
  typedef struct {
    bit                   barrier;
    bit                   write;
    logic [TIMEOUT_W-1:0] tmo;
    cmd_t                 c;
  } lock_job_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 rsp_valid;
  rsp_t                 rsp;
  logic                 idle_timeout_we = 1'b0;
  logic [TIMEOUT_W-1:0] idle_timeout_data = '0;

  fifo_lock_arbiter_idle_sleep dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .rsp_valid        (rsp_valid),
    .rsp              (rsp),
    .idle_timeout_we  (idle_timeout_we),
    .idle_timeout_data(idle_timeout_data)
  );

  lock_job_t job_backlog[$];
  rsp_t      due_rsp[$];
  int        err_count = 0;
  int        issued = 0;
  int        gen_timeout = int'(TIMEOUT_RESET);

  // Own copy of the lock server state.
  logic [TIMEOUT_W-1:0] model_timeout = TIMEOUT_RESET;
  logic                 lock_held = 1'b0;
  logic                 asleep = 1'b0;
  logic [TIMEOUT_W-1:0] quiet = '0;
  logic [REQ_W-1:0]     waiters[WAIT_DEPTH];
  logic [3:0]           wr_ptr = '0;
  logic [3:0]           rd_ptr = '0;
  logic [4:0]           n_waiting = '0;

  function automatic rsp_t make_rsp(logic [1:0] k, logic [TARGET_W-1:0] t);
    rsp_t r;
    r.kind   = k;
    r.target = t;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic logic [REQ_W-1:0] rand_id();
    return REQ_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] rand_func();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic void serve_lock_cmd(cmd_t c);
    rsp_t                 produced[$];
    logic [TIMEOUT_W-1:0] limit;
    limit = (model_timeout == '0) ? 16'd1 : model_timeout;
    case (c.func)
      FUNC_TICK: begin
        if (!lock_held && !asleep) begin
          if (quiet != TICKS_MAX) quiet++;
          if (quiet >= limit) begin
            quiet  = '0;
            asleep = 1'b1;
            produced.push_back(make_rsp(KIND_SLEEP, '0));
          end
        end
      end
      FUNC_ACQUIRE, FUNC_RELEASE: begin
        quiet = '0;
        if (asleep) begin
          asleep = 1'b0;
          produced.push_back(make_rsp(KIND_WAKE, '0));
        end
        if (c.func == FUNC_ACQUIRE) begin
          if (!lock_held) begin
            lock_held = 1'b1;
            produced.push_back(make_rsp(KIND_OK, c.requester));
          end else if (n_waiting == WAIT_DEPTH) begin
            produced.push_back(make_rsp(KIND_REJECT, c.requester));
          end else begin
            waiters[wr_ptr] = c.requester;
            wr_ptr++;
            n_waiting++;
          end
        end else begin
          // The releaser is answered whoever it is; the grant then passes on.
          produced.push_back(make_rsp(KIND_OK, c.requester));
          if (n_waiting != 0) begin
            produced.push_back(make_rsp(KIND_OK, waiters[rd_ptr]));
            rd_ptr++;
            n_waiting--;
          end else begin
            lock_held = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (produced.size() != 0) produced[produced.size() - 1].last = 1'b1;
    foreach (produced[i]) due_rsp.push_back(produced[i]);
  endfunction

  task automatic push_cmd(logic [1:0] f, logic [REQ_W-1:0] id);
    lock_job_t j;
    j.barrier     = 1'b0;
    j.write       = 1'b0;
    j.tmo         = '0;
    j.c.func      = f;
    j.c.requester = id;
    job_backlog.push_back(j);
    if (f != FUNC_UNUSED) issued++;
  endtask

  task automatic push_barrier(bit wr, logic [TIMEOUT_W-1:0] val);
    lock_job_t j;
    j.barrier = 1'b1;
    j.write   = wr;
    j.tmo     = val;
    j.c       = '0;
    job_backlog.push_back(j);
    if (wr) gen_timeout = int'(val);
  endtask

  // Grant, a run of waiters (sometimes past the queue depth), then the releases.
  task automatic add_contention();
    int n;
    int m;
    n = $urandom_range(1, 20);
    push_cmd(FUNC_ACQUIRE, rand_id());
    repeat (n) begin
      push_cmd(FUNC_ACQUIRE, rand_id());
      if ($urandom_range(0, 3) == 0) push_cmd(FUNC_TICK, rand_id());
    end
    m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n + 3) : n + 1;
    repeat (m) begin
      push_cmd(FUNC_RELEASE, rand_id());
      if ($urandom_range(0, 5) == 0) push_cmd(rand_func(), rand_id());
    end
  endtask

  // Quiet ticks around the timeout (at most 50 when it is larger), then a request that wakes the block if it slept.
  task automatic add_idle();
    int eff;
    int len;
    eff = (gen_timeout == 0) ? 1 : gen_timeout;
    len = (eff <= 50) ? $urandom_range(eff - 1, eff + 2) : $urandom_range(0, 50);
    repeat (len) push_cmd(FUNC_TICK, rand_id());
    push_cmd($urandom_range(0, 1) ? FUNC_ACQUIRE : FUNC_RELEASE, rand_id());
  endtask

  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return TIMEOUT_W'($urandom_range(4, 12));
      5: return TIMEOUT_W'($urandom_range(13, 50));
      default: return TIMEOUT_W'($urandom_range(51, 65535));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("fifo_lock_arbiter_idle_sleep_tb: done, errors");
    $finish;
  end

  // Driver: bursts of transfers separated by random gaps.
  int        gap_left = 0;
  int        burst_left = 0;
  int        settle = 0;
  logic      start_nx;
  logic      we_nx;
  lock_job_t head_job;

  always @(posedge clk) begin
    if (rst) begin
      start           <= 1'b0;
      idle_timeout_we <= 1'b0;
      settle = 0;
    end else begin
      start_nx = start;
      we_nx    = 1'b0;
      if (!(start && busy)) begin
        start_nx = 1'b0;
        if (job_backlog.size() != 0) begin
          if (job_backlog[0].barrier) begin
            if (start || busy || rsp_valid || due_rsp.size() != 0) settle = 0;
            else settle++;
            if (settle >= SETTLE_CYCLES) begin
              head_job = job_backlog.pop_front();
              if (head_job.write) begin
                we_nx = 1'b1;
                idle_timeout_data <= head_job.tmo;
              end
              settle = 0;
            end
          end else if (gap_left > 0) begin
            gap_left--;
          end else begin
            head_job = job_backlog.pop_front();
            start_nx = 1'b1;
            cmd <= head_job.c;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 30);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
      start           <= start_nx;
      idle_timeout_we <= we_nx;
    end
  end

  // Monitor: register writes and accepted transfers feed the prediction,
  // every result strobe is checked against the oldest one owed.
  rsp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (idle_timeout_we) model_timeout = idle_timeout_data;
      if (start && !busy) serve_lock_cmd(cmd);
      if (rsp_valid) begin
        if (due_rsp.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: kind %0d target %0h last %0b",
                     rsp.kind, rsp.target, rsp.last);
          err_count++;
        end else begin
          want = due_rsp.pop_front();
          if (rsp.kind !== want.kind || rsp.target !== want.target ||
              rsp.last !== want.last) begin
            if (err_count < 10)
              $display("result mismatch: want kind %0d target %0h last %0b, got %0d %0h %0b",
                       want.kind, want.target, want.last, rsp.kind, rsp.target, rsp.last);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    // Directed: grant, queueing, ignored items, hand-over, release while free.
    push_cmd(FUNC_ACQUIRE, 8'h00);
    push_cmd(FUNC_ACQUIRE, 8'hFF);
    push_cmd(FUNC_TICK, 8'h00);
    push_cmd(FUNC_UNUSED, 8'h3C);
    push_cmd(FUNC_RELEASE, 8'h00);
    push_cmd(FUNC_RELEASE, 8'hAA);
    push_cmd(FUNC_RELEASE, 8'h55);
    repeat (6) push_cmd(FUNC_TICK, 8'hC3);
    // Lowering the timeout below the count already reached sleeps on the next tick.
    push_barrier(1'b1, 16'd5);
    push_cmd(FUNC_TICK, 8'h00);
    push_cmd(FUNC_TICK, 8'h00);
    push_cmd(FUNC_ACQUIRE, 8'h81);
    push_barrier(1'b1, 16'd0);
    push_cmd(FUNC_RELEASE, 8'h81);
    push_cmd(FUNC_TICK, 8'h18);
    push_cmd(FUNC_RELEASE, 8'h7E);
    push_barrier(1'b1, 16'd1);

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_contention();
        5, 6: add_idle();
        7: repeat ($urandom_range(1, 5)) push_cmd(rand_func(), rand_id());
        8: push_barrier(1'b1, pick_timeout());
        default: push_barrier(1'b0, '0);
      endcase
    end

    // Free the lock whatever state it is in, then sleep and wake once more.
    repeat (WAIT_DEPTH + 1) push_cmd(FUNC_RELEASE, rand_id());
    push_barrier(1'b1, 16'd3);
    repeat (3) push_cmd(FUNC_TICK, rand_id());
    push_cmd(FUNC_TICK, 8'h00);
    push_cmd(FUNC_ACQUIRE, 8'h42);
    push_cmd(FUNC_RELEASE, 8'h42);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (job_backlog.size() != 0 || start) @(posedge clk);
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && due_rsp.size() == 0) begin
      $display("fifo_lock_arbiter_idle_sleep_tb: done, clean");
    end else begin
      $display("fifo_lock_arbiter_idle_sleep_tb: done, errors");
    end
    $finish;
  end

endmodule
